FILE: src/next_fit_free_list_allocator_top_defines.svh
`ifndef NEXT_FIT_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define NEXT_FIT_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define NFFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NFFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/nffl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nffl_pkg;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } seg_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_F_RD,
    ST_F_CHK,
    ST_F_DEC,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_WR,
    ST_DONE
  } state_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic CFG_HEAP = 1'b0;
  localparam logic CFG_HDR  = 1'b1;

  localparam logic [31:0] HEAP_RESET = 32'd4194304;
  localparam logic [6:0]  HDR_RESET  = 7'd16;

  function automatic logic [31:0] sat32(input logic [34:0] v);
    sat32 = (v[34:32] != 3'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/nffl_seg_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module nffl_seg_mem #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  wire logic           clk,
  input  wire logic           rd_en,
  input  wire logic [IW-1:0]  rd_addr,
  output nffl_pkg::seg_t      rd_data,
  input  wire logic           wr_en,
  input  wire logic [IW-1:0]  wr_addr,
  input  nffl_pkg::seg_t      wr_data
);

  nffl_pkg::seg_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/nffl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module nffl_ctrl #(
  parameter int MAX_SEGMENTS = 64,
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [31:0]   cfg_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_type,
  input  wire logic [31:0]   in_req,
  input  wire logic [31:0]   in_addr,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_status,
  output logic [31:0]        out_daddr,
  output logic [31:0]        out_gnt,
  output logic               rd_en,
  output logic [IW-1:0]      rd_addr,
  input  nffl_pkg::seg_t     rd_data,
  output logic               wr_en,
  output logic [IW-1:0]      wr_addr,
  output nffl_pkg::seg_t     wr_data
);

  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

  nffl_pkg::state_t state, state_next;

  logic [31:0]   heap;
  logic [6:0]    hdr;
  logic [CW-1:0] cnt;
  logic [IW-1:0] rover;
  logic [IW-1:0] idx;
  logic [CW-1:0] steps;
  logic [CW-1:0] p;
  logic [IW-1:0] j;
  logic [IW-1:0] jend;
  logic          ins;
  logic [31:0]   req;
  logic [31:0]   hdr_addr;
  nffl_pkg::seg_t prv;
  nffl_pkg::seg_t cur;
  logic [1:0]    res_status;
  logic [31:0]   res_daddr;
  logic [31:0]   res_gnt;

  // allocate check
  logic [32:0] need;
  logic        fits, exact;
  logic [31:0] rest;
  logic [IW-1:0] idx_nxt;
  // free decision
  logic        have_prev, have_cur, mn, mp;
  logic [34:0] sum_both, sum_mp, sum_mn;
  logic        out_load;

  assign need  = {1'b0, req} + 33'(hdr);
  assign fits  = {1'b0, rd_data.size} >= need;
  assign exact = {1'b0, rd_data.size} == need;
  assign rest  = rd_data.size - need[31:0];
  assign idx_nxt = (CW'(idx) + CW'(1) == cnt) ? '0 : idx + IW'(1);

  assign have_prev = p != '0;
  assign have_cur  = p < cnt;
  assign mn = have_cur &&
              ({2'b0, hdr_addr} + 34'(hdr) + {2'b0, req} == {2'b0, cur.start});
  assign mp = have_prev &&
              ({2'b0, prv.start} + 34'(hdr) + {2'b0, prv.size} == {2'b0, hdr_addr});
  assign sum_both = {3'b0, prv.size} + 35'(hdr) + {3'b0, req} + 35'(hdr)
                  + {3'b0, cur.size};
  assign sum_mp   = {3'b0, prv.size} + 35'(hdr) + {3'b0, req};
  assign sum_mn   = {3'b0, req} + 35'(hdr) + {3'b0, cur.size};

  assign in_ready = state == nffl_pkg::ST_IDLE;
  assign out_load = (state == nffl_pkg::ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nffl_pkg::ST_INIT;
    end else if (cfg_we) begin
      state <= nffl_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en   = 1'b0;
    rd_addr = idx;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    unique case (state)
      nffl_pkg::ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data.start = '0;
        wr_data.size  = (heap >= 32'(hdr)) ? heap - 32'(hdr) : '0;
        state_next = nffl_pkg::ST_IDLE;
      end
      nffl_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_type == nffl_pkg::REQ_ALLOC) begin
            state_next = (cnt == '0) ? nffl_pkg::ST_DONE : nffl_pkg::ST_A_RD;
          end else begin
            state_next = (cnt == '0) ? nffl_pkg::ST_F_DEC : nffl_pkg::ST_F_RD;
          end
        end
      end
      nffl_pkg::ST_A_RD: begin
        rd_en = 1'b1;
        state_next = nffl_pkg::ST_A_CHK;
      end
      nffl_pkg::ST_A_CHK: begin
        if (!fits) begin
          state_next = (steps == CW'(1)) ? nffl_pkg::ST_DONE : nffl_pkg::ST_A_RD;
        end else if (exact) begin
          state_next = (CW'(idx) < cnt - CW'(1)) ? nffl_pkg::ST_SH_RD : nffl_pkg::ST_DONE;
        end else begin
          wr_en = 1'b1;
          wr_data.start = rd_data.start;
          wr_data.size  = rest;
          state_next = nffl_pkg::ST_DONE;
        end
      end
      nffl_pkg::ST_F_RD: begin
        rd_en   = 1'b1;
        rd_addr = IW'(p);
        state_next = nffl_pkg::ST_F_CHK;
      end
      nffl_pkg::ST_F_CHK: begin
        if (rd_data.start <= hdr_addr) begin
          state_next = (p + CW'(1) == cnt) ? nffl_pkg::ST_F_DEC : nffl_pkg::ST_F_RD;
        end else begin
          state_next = nffl_pkg::ST_F_DEC;
        end
      end
      nffl_pkg::ST_F_DEC: begin
        if (mp) begin
          wr_en   = 1'b1;
          wr_addr = IW'(p - CW'(1));
          wr_data.start = prv.start;
          wr_data.size  = nffl_pkg::sat32(mn ? sum_both : sum_mp);
          state_next = (mn && (p < cnt - CW'(1))) ? nffl_pkg::ST_SH_RD : nffl_pkg::ST_DONE;
        end else if (mn) begin
          wr_en   = 1'b1;
          wr_addr = IW'(p);
          wr_data.start = hdr_addr;
          wr_data.size  = nffl_pkg::sat32(sum_mn);
          state_next = nffl_pkg::ST_DONE;
        end else if (cnt >= MAXC) begin
          state_next = nffl_pkg::ST_DONE;
        end else begin
          state_next = have_cur ? nffl_pkg::ST_SH_RD : nffl_pkg::ST_INS_WR;
        end
      end
      nffl_pkg::ST_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = ins ? j : j + IW'(1);
        state_next = nffl_pkg::ST_SH_WR;
      end
      nffl_pkg::ST_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = ins ? j + IW'(1) : j;
        wr_data = rd_data;
        if (j == jend) begin
          state_next = ins ? nffl_pkg::ST_INS_WR : nffl_pkg::ST_DONE;
        end else begin
          state_next = nffl_pkg::ST_SH_RD;
        end
      end
      nffl_pkg::ST_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = IW'(p);
        wr_data.start = hdr_addr;
        wr_data.size  = req;
        state_next = nffl_pkg::ST_DONE;
      end
      nffl_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = nffl_pkg::ST_IDLE;
        end
      end
      default: state_next = nffl_pkg::ST_INIT;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap <= nffl_pkg::HEAP_RESET;
      hdr  <= nffl_pkg::HDR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nffl_pkg::CFG_HEAP: heap <= cfg_data;
        nffl_pkg::CFG_HDR:  hdr  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= CW'(1);
      rover <= '0;
    end else begin
      unique case (state)
        nffl_pkg::ST_INIT: begin
          cnt   <= CW'(1);
          rover <= '0;
        end
        nffl_pkg::ST_A_CHK: begin
          if (fits && exact) begin
            cnt <= cnt - CW'(1);
            if (cnt == CW'(1)) begin
              rover <= '0;
            end else begin
              rover <= (idx != '0) ? idx - IW'(1) : IW'(cnt - CW'(2));
            end
          end else if (fits) begin
            rover <= (idx == '0) ? IW'(cnt - CW'(1)) : idx - IW'(1);
          end
        end
        nffl_pkg::ST_F_DEC: begin
          if (mp) begin
            rover <= IW'(p - CW'(1));
            if (mn) begin
              cnt <= cnt - CW'(1);
            end
          end else if (mn) begin
            rover <= have_prev ? IW'(p - CW'(1)) : IW'(cnt - CW'(1));
          end else if (cnt < MAXC) begin
            cnt   <= cnt + CW'(1);
            rover <= have_prev ? IW'(p - CW'(1)) : IW'(cnt);
          end
        end
        default: ;
      endcase
    end
  end

  // per-request datapath
  always_ff @(posedge clk) begin
    unique case (state)
      nffl_pkg::ST_IDLE: begin
        req        <= in_req;
        hdr_addr   <= in_addr - 32'(hdr);
        idx        <= (CW'(rover) + CW'(1) == cnt) ? '0 : rover + IW'(1);
        steps      <= cnt;
        p          <= '0;
        res_status <= (in_type == nffl_pkg::REQ_ALLOC && cnt == '0)
                      ? nffl_pkg::STAT_NOFIT : nffl_pkg::STAT_OK;
        res_daddr  <= '0;
        res_gnt    <= '0;
      end
      nffl_pkg::ST_A_CHK: begin
        if (!fits) begin
          steps <= steps - CW'(1);
          idx   <= idx_nxt;
          if (steps == CW'(1)) begin
            res_status <= nffl_pkg::STAT_NOFIT;
          end
        end else if (exact) begin
          res_daddr <= rd_data.start + 32'(hdr);
          res_gnt   <= rd_data.size;
          ins  <= 1'b0;
          j    <= idx;
          jend <= IW'(cnt - CW'(2));
        end else begin
          res_daddr <= rd_data.start + rest + {24'b0, hdr, 1'b0};
          res_gnt   <= req;
        end
      end
      nffl_pkg::ST_F_CHK: begin
        if (rd_data.start <= hdr_addr) begin
          prv <= rd_data;
          p   <= p + CW'(1);
        end else begin
          cur <= rd_data;
        end
      end
      nffl_pkg::ST_F_DEC: begin
        if (mp) begin
          ins  <= 1'b0;
          j    <= IW'(p);
          jend <= IW'(cnt - CW'(2));
        end else if (!mn) begin
          if (cnt >= MAXC) begin
            res_status <= nffl_pkg::STAT_FULL;
          end
          ins  <= 1'b1;
          j    <= IW'(cnt - CW'(1));
          jend <= IW'(p);
        end
      end
      nffl_pkg::ST_SH_WR: begin
        j <= ins ? j - IW'(1) : j + IW'(1);
      end
      default: ;
    endcase
  end

  // result register: the next request may start while this one waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_daddr  <= res_daddr;
      out_gnt    <= res_gnt;
    end
  end

endmodule

`default_nettype wire

FILE: src/next_fit_free_list_allocator_top.sv
// Next-fit free-list heap allocator.
// Input stream (s_*): one beat per request. s_tuser is the request kind
// (0 allocate, 1 free); s_tdata carries request_bytes and block_address.
// Output stream (m_*): exactly one beat per request, in order. m_tuser is
// the status (0 ok, 1 no fit, 2 table full); m_tdata carries data_address
// and granted_bytes, both zero unless an allocate succeeds.
// Config port: cfg_we with cfg_index 0 (heap_bytes) or 1 (header_bytes);
// any write rebuilds the table as one free segment.
// An allocate reads and checks each segment visited, then moves entries
// down to close the gap when an exact fit removes a segment; a free reads
// each segment scanned up to the insert point, then moves entries as needed.
// The pace is set by the segment table (one read port and one write port,
// one read and one write per cycle), walked by one sequencer.
// One request is in flight at a time; s_tready is high only when idle.
// The result sits in an output register, so the next request is taken
// while it waits; a stalled m_tready holds that request at its end.
// Reset (rst, synchronous) restores the default registers and a table
// rebuild follows before the first beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module next_fit_free_list_allocator_top #(
  parameter int MAX_SEGMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // request_bytes[31:0], block_address[63:32]
  input  wire logic        s_tuser,   // req_type[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // data_address[31:0], granted_bytes[63:32]
  output logic [1:0]       m_tuser    // status[1:0]
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  logic           rd_en, wr_en;
  logic [IW-1:0]  rd_addr, wr_addr;
  nffl_pkg::seg_t rd_data, wr_data;
  logic [31:0]    daddr, gnt;

  nffl_seg_mem #(.DEPTH(MAX_SEGMENTS), .IW(IW)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  nffl_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS), .IW(IW), .CW(CW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_type    (s_tuser),
    .in_req     (s_tdata[31:0]),
    .in_addr    (s_tdata[63:32]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_daddr  (daddr),
    .out_gnt    (gnt),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  assign m_tdata = {gnt, daddr};

endmodule

`default_nettype wire

FILE: src/nffl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "next_fit_free_list_allocator_top_defines.svh"

module nffl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  `NFFL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `NFFL_ASSERT_NOW(a_status_code, m_tvalid, m_tuser <= nffl_pkg::STAT_FULL, "undefined status code")
  `NFFL_ASSERT_NOW(a_fail_zero, m_tvalid && (m_tuser != nffl_pkg::STAT_OK), m_tdata == 64'd0, "failed beat carries data")
  `NFFL_ASSERT_NOW(a_reset_quiet, $past(rst), !m_tvalid && !s_tready, "activity right after reset")

endmodule

bind next_fit_free_list_allocator_top nffl_checker u_nffl_checker (.*);

`default_nettype wire

FILE: tb/sv/next_fit_free_list_allocator_top_tb.sv
`timescale 1ns / 1ps

module next_fit_free_list_allocator_top_tb;

  localparam int NSEG = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic        kind;
    logic [31:0] nbytes;
    logic [31:0] addr;
  } req_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] data_address;
    logic [31:0] granted_bytes;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = nffl_pkg::CFG_HEAP;
  logic [31:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;   // request_bytes[31:0], block_address[63:32]
  logic s_tuser = 1'b0;        // req_type[0]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;        // data_address[31:0], granted_bytes[63:32]
  logic [1:0] m_tuser;         // status[1:0]

  next_fit_free_list_allocator_top #(.MAX_SEGMENTS(NSEG)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial forever #5 clk = ~clk;

  // predictor state
  logic [31:0] heap_sz = nffl_pkg::HEAP_RESET;
  logic [31:0] hdr_sz = 32'(nffl_pkg::HDR_RESET);
  logic [31:0] seg_start [NSEG];
  logic [31:0] seg_size [NSEG];
  int seg_cnt;
  int rover;

  req_t pending_reqs[$];
  resp_t expected_resps[$];
  resp_t live_blocks[$];   // granted blocks not yet freed, for well-formed frees
  int fails = 0;
  int cycles = 0;
  int send_idle = 33;
  int recv_idle = 73;

  function automatic logic [31:0] sat(logic [33:0] v);
    return (v > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic void rebuild_table();
    for (int i = 0; i < NSEG; i++) begin
      seg_start[i] = '0;
      seg_size[i] = '0;
    end
    seg_size[0] = (heap_sz >= hdr_sz) ? heap_sz - hdr_sz : '0;
    seg_cnt = 1;
    rover = 0;
  endfunction

  function automatic void drop_seg(int i);
    for (int j = i; j < seg_cnt - 1; j++) begin
      seg_start[j] = seg_start[j+1];
      seg_size[j] = seg_size[j+1];
    end
    seg_cnt--;
  endfunction

  function automatic void add_seg(int i, logic [31:0] st, logic [31:0] sz);
    for (int j = seg_cnt; j > i; j--) begin
      seg_start[j] = seg_start[j-1];
      seg_size[j] = seg_size[j-1];
    end
    seg_start[i] = st;
    seg_size[i] = sz;
    seg_cnt++;
  endfunction

  function automatic resp_t heap_predict(req_t r);
    resp_t o;
    logic [32:0] need, rest;
    logic [31:0] hdr, blk;
    int idx, prev, p;
    bit mn, mp;
    o = '{nffl_pkg::STAT_OK, 32'd0, 32'd0};
    if (r.kind == nffl_pkg::REQ_ALLOC) begin
      need = {1'b0, r.nbytes} + {1'b0, hdr_sz};
      o.status = nffl_pkg::STAT_NOFIT;
      for (int k = 1; k <= seg_cnt; k++) begin
        idx = (rover + k) % seg_cnt;
        if ({1'b0, seg_size[idx]} < need) continue;
        prev = (idx + seg_cnt - 1) % seg_cnt;
        o.status = nffl_pkg::STAT_OK;
        if ({1'b0, seg_size[idx]} == need) begin
          o.data_address = seg_start[idx] + hdr_sz;
          o.granted_bytes = seg_size[idx];
          drop_seg(idx);
          rover = (seg_cnt == 0) ? 0 : (prev < idx ? prev : prev - 1);
        end else begin
          rest = {1'b0, seg_size[idx]} - need;
          blk = seg_start[idx] + hdr_sz + rest[31:0];
          seg_size[idx] = rest[31:0];
          o.data_address = blk + hdr_sz;
          o.granted_bytes = r.nbytes;
          rover = prev;
        end
        break;
      end
    end else begin
      hdr = r.addr - hdr_sz;
      p = 0;
      while (p < seg_cnt && seg_start[p] <= hdr) p++;
      mn = p < seg_cnt &&
           ({2'b0, hdr} + {2'b0, hdr_sz} + {2'b0, r.nbytes}) == {2'b0, seg_start[p]};
      mp = p > 0 &&
           ({2'b0, seg_start[p-1]} + {2'b0, hdr_sz} + {2'b0, seg_size[p-1]}) == {2'b0, hdr};
      if (mp && mn) begin
        seg_size[p-1] = sat({2'b0, seg_size[p-1]} + hdr_sz + r.nbytes + hdr_sz + seg_size[p]);
        drop_seg(p);
        rover = p - 1;
      end else if (mp) begin
        seg_size[p-1] = sat({2'b0, seg_size[p-1]} + hdr_sz + r.nbytes);
        rover = p - 1;
      end else if (mn) begin
        seg_start[p] = hdr;
        seg_size[p] = sat({2'b0, r.nbytes} + hdr_sz + seg_size[p]);
        rover = p > 0 ? p - 1 : seg_cnt - 1;
      end else if (seg_cnt >= NSEG) begin
        o.status = nffl_pkg::STAT_FULL;
      end else begin
        add_seg(p, hdr, r.nbytes);
        rover = p > 0 ? p - 1 : seg_cnt - 1;
      end
    end
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          req_t r;
          r = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= r.kind;
          s_tdata <= {r.addr, r.nbytes};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_resps.size() == 0) begin
        $error("unexpected result beat status=%0d", m_tuser);
        fails++;
      end else begin
        resp_t e;
        e = expected_resps.pop_front();
        if (m_tuser !== e.status) begin
          $error("status exp %0d got %0d", e.status, m_tuser);
          fails++;
        end
        if (m_tdata[31:0] !== e.data_address) begin
          $error("data_address exp %h got %h", e.data_address, m_tdata[31:0]);
          fails++;
        end
        if (m_tdata[63:32] !== e.granted_bytes) begin
          $error("granted_bytes exp %h got %h", e.granted_bytes, m_tdata[63:32]);
          fails++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // requests are predicted in queue order, so the model runs ahead of the DUT
  task automatic push_req(logic kind, logic [31:0] nb, logic [31:0] ad);
    req_t r;
    r = '{kind, nb, ad};
    pending_reqs.push_back(r);
    expected_resps.push_back(heap_predict(r));
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || s_tvalid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (4 * NSEG + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == nffl_pkg::CFG_HEAP) heap_sz = val;
    else hdr_sz = {25'd0, val[6:0]};
    rebuild_table();
    repeat (4) @(posedge clk);
  endtask

  // mostly alloc/free of live blocks with some bogus frees mixed in
  task automatic random_phase(int n, int max_req);
    int bi;
    for (int i = 0; i < n; i++) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) begin
        push_req(nffl_pkg::REQ_ALLOC, (pick < 3) ? $urandom : 32'($urandom_range(max_req)),
                 $urandom);
        if (expected_resps[$].status == nffl_pkg::STAT_OK)
          live_blocks.push_back(expected_resps[$]);
      end else if (pick < 90 && live_blocks.size() > 0) begin
        bi = $urandom_range(live_blocks.size() - 1);
        push_req(nffl_pkg::REQ_FREE, live_blocks[bi].granted_bytes,
                 live_blocks[bi].data_address);
        live_blocks.delete(bi);
      end else begin
        push_req(nffl_pkg::REQ_FREE, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rebuild_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // directed: extremes, exact fit, empty table, table full
    push_req(nffl_pkg::REQ_ALLOC, 32'd0, 32'd0);
    push_req(nffl_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(nffl_pkg::REQ_ALLOC, 32'd100, 32'd0);
    push_req(nffl_pkg::REQ_FREE, 32'd100, 32'h003F_FFA0);
    push_req(nffl_pkg::REQ_FREE, 32'hFFFF_FFFF, 32'd0);
    push_req(nffl_pkg::REQ_FREE, 32'd8, 32'hFFFF_FFF0);
    drain();
    write_reg(nffl_pkg::CFG_HEAP, 32'd64);
    write_reg(nffl_pkg::CFG_HDR, 32'd0);
    push_req(nffl_pkg::REQ_ALLOC, 32'd64, 32'd0);   // exact fit empties table
    push_req(nffl_pkg::REQ_ALLOC, 32'd1, 32'd0);
    push_req(nffl_pkg::REQ_FREE, 32'd64, 32'd0);
    drain();
    write_reg(nffl_pkg::CFG_HDR, 32'd64);
    push_req(nffl_pkg::REQ_ALLOC, 32'd0, 32'd0);
    push_req(nffl_pkg::REQ_FREE, 32'd4, 32'd200);
    drain();
    write_reg(nffl_pkg::CFG_HEAP, 32'hFFFF_FFFF);
    write_reg(nffl_pkg::CFG_HDR, 32'd1);
    for (int i = 0; i < 68; i++)
      push_req(nffl_pkg::REQ_FREE, 32'd1, 32'hF000_0000 + 32'(i * 8));
    drain();

    live_blocks.delete();
    write_reg(nffl_pkg::CFG_HEAP, 32'd4096);
    write_reg(nffl_pkg::CFG_HDR, 32'd16);
    random_phase(700, 200);
    drain();
    send_idle = 73;
    recv_idle = 33;
    live_blocks.delete();
    write_reg(nffl_pkg::CFG_HEAP, 32'hFFFF_FFFF);
    write_reg(nffl_pkg::CFG_HDR, 32'(nffl_pkg::HDR_RESET));
    random_phase(650, 100000);
    drain();
    send_idle = 0;
    recv_idle = 0;
    live_blocks.delete();
    write_reg(nffl_pkg::CFG_HDR, 32'd8);
    write_reg(nffl_pkg::CFG_HEAP, 32'd1024);
    random_phase(650, 64);
    drain();

    if (fails == 0 && expected_resps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: next_fit_free_list_allocator_top.f
+incdir+src
src/nffl_pkg.sv
src/nffl_seg_mem.sv
src/nffl_ctrl.sv
src/next_fit_free_list_allocator_top.sv
src/nffl_checker.sv
tb/sv/next_fit_free_list_allocator_top_tb.sv
